### rtl/ole_pkg.sv
// Package for the ordered list engine: request and result types, status
// and request codes, and the command that the top level broadcasts to the cells.
// No dependencies.
package ole_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned CNT_OUT_W = 7;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_FIND   = 3'd5,
    REQ_READ   = 3'd6,
    REQ_NONE   = 3'd7
  } req_type_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    req_type_e                req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [IDX_OUT_W-1:0]     found_index;
    logic [CNT_OUT_W-1:0]     item_count;
    logic                     is_empty;
  } res_t;

  // what each cell does with its entry in the update cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_DELETE,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

### rtl/ole_cell.sv
// One cell of the list: holds the entry at a fixed index, probes it against
// an incoming request and shifts with its neighbours on insert, delete and remove.
// Depends on ole_pkg.
module ole_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic                              clk_i,
  input  logic                              accept_i,
  input  ole_pkg::req_t                     probe_i,
  input  logic [CW-1:0]                     count_i,
  input  ole_pkg::cell_cmd_t                cmd_i,
  input  logic                              tail_i,
  input  logic signed [ole_pkg::DATA_W-1:0] prev_i,
  input  logic signed [ole_pkg::DATA_W-1:0] next_i,
  output logic signed [ole_pkg::DATA_W-1:0] entry_o,
  output logic                              match_o,
  output logic signed [ole_pkg::DATA_W-1:0] rdata_o
);

  localparam int unsigned CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;
  localparam logic [CMPW-1:0] IDX_X = CMPW'(IDX);

  logic signed [ole_pkg::DATA_W-1:0] entry_q, entry_d;
  logic signed [ole_pkg::DATA_W-1:0] rdata_q, rdata_d;
  logic                              match_q, match_d;
  logic [CMPW-1:0]                   cnt_x, probe_pos_x, cmd_pos_x;

  assign cnt_x       = CMPW'(count_i);
  assign probe_pos_x = CMPW'(probe_i.position);
  assign cmd_pos_x   = CMPW'(cmd_i.pos);

  // probe: value compare and positional select, captured on acceptance
  always_comb begin
    match_d = (entry_q == probe_i.value) && (IDX_X < cnt_x);
    rdata_d = (IDX_X == probe_pos_x) ? entry_q : '0;
  end

  // update: take the new value or a neighbour's entry
  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      ole_pkg::CELL_PUSH: begin
        if (IDX_X == cnt_x) entry_d = cmd_i.value;
      end
      ole_pkg::CELL_INSERT: begin
        if (IDX_X == cmd_pos_x) entry_d = cmd_i.value;
        else if (IDX_X > cmd_pos_x) entry_d = prev_i;
      end
      ole_pkg::CELL_DELETE: begin
        if (IDX_X >= cmd_pos_x) entry_d = next_i;
      end
      ole_pkg::CELL_REMOVE: begin
        if (tail_i) entry_d = next_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (accept_i) begin
      match_q <= match_d;
      rdata_q <= rdata_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign rdata_o = rdata_q;

endmodule

### rtl/ordered_list_engine_core.sv
// Ordered list engine top level: a chain of list cells plus the request
// sequencing, first-match resolution and result register.
// Depends on ole_pkg and ole_cell.
//
// Keeps a packed list of up to DEPTH signed 32-bit values. A request is taken
// when start is high and busy is low; busy is then high for one cycle, and no
// new request is taken while it is high. In the accept cycle every cell
// compares its entry with the request in parallel and registers the outcome;
// in the busy cycle the first match is resolved, the count is updated and all
// cells shift at once. The result is registered on res_o, marked by done_o for
// one cycle, in the cycle after busy, which is also a cycle in which the
// next request can be taken. Results cannot be held off, so they must be
// captured when done_o is high. Entries above the count are never read.
module ordered_list_engine_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ole_pkg::req_t req_i,
  output logic          done_o,
  output ole_pkg::res_t res_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;
  localparam int unsigned XW   = CW + ole_pkg::CNT_OUT_W + ole_pkg::IDX_OUT_W;

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        count_q, count_d;
  ole_pkg::req_t        req_q;
  ole_pkg::res_t        res_q, res_d;
  logic                 accept;

  logic signed [ole_pkg::DATA_W-1:0] entry [DEPTH];
  logic signed [ole_pkg::DATA_W-1:0] rdata [DEPTH];
  logic [DEPTH-1:0]     match, neg_match, first_hit, tail;
  ole_pkg::cell_cmd_t   cmd;

  logic                 any_match;
  logic [IW-1:0]        hit_idx;
  logic signed [ole_pkg::DATA_W-1:0] rd_or;
  logic [CMPW-1:0]      pos_x, cnt_x;
  logic [XW-1:0]        cnt_out_x, idx_out_x;

  assign accept = start && !busy_q;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ole_pkg::DATA_W-1:0] prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = entry[g];
    end else begin : g_prev
      assign prev_e = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_e = entry[g];
    end else begin : g_next
      assign next_e = entry[g+1];
    end

    ole_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .accept_i (accept),
      .probe_i  (req_i),
      .count_i  (count_q),
      .cmd_i    (cmd),
      .tail_i   (tail[g]),
      .prev_i   (prev_e),
      .next_i   (next_e),
      .entry_o  (entry[g]),
      .match_o  (match[g]),
      .rdata_o  (rdata[g])
    );
  end

  // first match: isolate the lowest set bit and everything above it
  assign neg_match = ~match + DEPTH'(1);
  assign first_hit = match & neg_match;
  assign tail      = match | neg_match;
  assign any_match = |match;

  // encode the hit and gather the selected entry
  always_comb begin
    hit_idx = '0;
    rd_or   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) hit_idx = hit_idx | IW'(i);
      rd_or = rd_or | rdata[i];
    end
  end

  assign pos_x = CMPW'(req_q.position);
  assign cnt_x = CMPW'(count_q);

  // resolve the request held in the busy cycle
  always_comb begin
    res_d.status      = ole_pkg::ST_OK;
    res_d.read_value  = '0;
    res_d.found_index = '0;
    count_d           = count_q;
    cmd.op            = ole_pkg::CELL_HOLD;
    cmd.pos           = req_q.position;
    cmd.value         = req_q.value;
    idx_out_x         = '0;
    if (busy_q) begin
      unique case (req_q.req_type)
        ole_pkg::REQ_PUSH: begin
          if (count_q >= CW'(DEPTH)) begin
            res_d.status = ole_pkg::ST_FULL;
          end else begin
            cmd.op  = ole_pkg::CELL_PUSH;
            count_d = count_q + CW'(1);
          end
        end
        ole_pkg::REQ_POP: begin
          if (count_q == '0) res_d.status = ole_pkg::ST_EMPTY;
          else count_d = count_q - CW'(1);
        end
        ole_pkg::REQ_INSERT: begin
          if (count_q >= CW'(DEPTH)) begin
            res_d.status = ole_pkg::ST_FULL;
          end else if (pos_x > cnt_x) begin
            res_d.status = ole_pkg::ST_BADPOS;
          end else begin
            cmd.op  = ole_pkg::CELL_INSERT;
            count_d = count_q + CW'(1);
          end
        end
        ole_pkg::REQ_DELETE: begin
          if (pos_x >= cnt_x) begin
            res_d.status = ole_pkg::ST_BADPOS;
          end else begin
            cmd.op  = ole_pkg::CELL_DELETE;
            count_d = count_q - CW'(1);
          end
        end
        ole_pkg::REQ_REMOVE: begin
          if (!any_match) begin
            res_d.status = ole_pkg::ST_NOTFOUND;
          end else begin
            cmd.op  = ole_pkg::CELL_REMOVE;
            count_d = count_q - CW'(1);
          end
        end
        ole_pkg::REQ_FIND: begin
          if (!any_match) res_d.status = ole_pkg::ST_NOTFOUND;
          else idx_out_x = XW'(hit_idx);
        end
        ole_pkg::REQ_READ: begin
          if (pos_x >= cnt_x) res_d.status = ole_pkg::ST_BADPOS;
          else res_d.read_value = rd_or;
        end
        default: begin
          res_d.status = ole_pkg::ST_OK;
        end
      endcase
    end
    res_d.found_index = idx_out_x[ole_pkg::IDX_OUT_W-1:0];
    cnt_out_x         = XW'(count_d);
    res_d.item_count  = cnt_out_x[ole_pkg::CNT_OUT_W-1:0];
    res_d.is_empty    = (count_d == '0);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= accept;
      done_q  <= busy_q;
      count_q <= count_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (busy_q) res_q <= res_d;
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above capacity");

  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("busy held for more than one cycle");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("result strobe without a request in progress");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.is_empty == (count_q == '0)))
    else $error("empty flag disagrees with the count");

endmodule

### tb/ordered_list_engine_core_tb.sv
// Self-checking testbench for ordered_list_engine_core: a directed request table with
// expected results, then biased random requests checked against a shadow list in the testbench.
// Depends on ole_pkg and the ordered_list_engine_core RTL.
module ordered_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned N_DIRECTED  = 25;
  localparam int unsigned N_RANDOM    = 1250;
  localparam int unsigned SEGMENT_LEN = 60;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

  // traffic mix of a random segment
  typedef enum int unsigned {
    MIX_GROW   = 0,
    MIX_SHRINK = 1,
    MIX_EVEN   = 2
  } traffic_mix_e;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  req_t req_i;
  res_t res_o;

  // shadow of the list held by the block
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int unsigned              shadow_count;

  res_t          expected_results [$];
  directed_row_t directed_rows [N_DIRECTED];
  int unsigned   errors;
  int unsigned   cycle_count;
  bit            back_to_back;
  res_t          got_res;
  res_t          want_res;

  // weights per request code (push .. none) for each traffic mix
  int unsigned mix_weights [3][8] = '{
    '{40,  3, 30,  3,  4, 10,  8, 2},
    '{ 4, 30,  4, 25, 17, 10,  8, 2},
    '{15, 12, 13, 12, 13, 15, 15, 5}
  };
  traffic_mix_e segment_plan [6] = '{MIX_GROW, MIX_GROW, MIX_EVEN,
                                     MIX_SHRINK, MIX_SHRINK, MIX_EVEN};

  ordered_list_engine_core #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // apply one request to the shadow list and return the result it should give
  function automatic res_t list_apply(req_t r);
    res_t        res;
    bit          found;
    bit          hit_ok;
    int unsigned hit;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    hit = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!found && shadow_entries[i] == r.value) begin
        found = 1'b1;
        hit = i;
      end
    end
    case (r.req_type)
      REQ_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = r.value;
          shadow_count++;
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      REQ_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (r.position > shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (int unsigned i = shadow_count; i > r.position; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[r.position] = r.value;
          shadow_count++;
        end
      end
      REQ_DELETE, REQ_REMOVE: begin
        // both close the gap; they differ in how the victim is chosen and in the failure status
        if (r.req_type == REQ_DELETE) begin
          hit_ok = r.position < shadow_count;
          hit = r.position;
        end else begin
          hit_ok = found;
        end
        if (!hit_ok) begin
          res.status = (r.req_type == REQ_DELETE) ? ST_BADPOS : ST_NOTFOUND;
        end else begin
          for (int unsigned i = hit; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      REQ_FIND: begin
        if (found) res.found_index = hit[IDX_OUT_W-1:0];
        else res.status = ST_NOTFOUND;
      end
      REQ_READ: begin
        if (r.position >= shadow_count) res.status = ST_BADPOS;
        else res.read_value = shadow_entries[r.position];
      end
      default: ;
    endcase
    res.item_count = shadow_count[CNT_OUT_W-1:0];
    res.is_empty   = (shadow_count == 0);
    return res;
  endfunction

  // random request; values lean towards ones already in the list so that
  // remove and find hit often
  function automatic req_t random_req(traffic_mix_e mix);
    req_t        r;
    int unsigned roll;
    int unsigned code;
    roll = $urandom_range(0, 99);
    code = 0;
    while (code < 7 && roll >= mix_weights[mix][code]) begin
      roll -= mix_weights[mix][code];
      code++;
    end
    r.req_type = req_type_e'(code[2:0]);
    if ($urandom_range(0, 4) == 0) r.position = POS_W'($urandom_range(0, 127));
    else r.position = POS_W'($urandom_range(0, shadow_count));
    roll = $urandom_range(0, 9);
    if (roll < 4 && shadow_count != 0) begin
      r.value = shadow_entries[$urandom_range(0, shadow_count - 1)];
    end else if (roll < 7) begin
      case ($urandom_range(0, 5))
        0:       r.value = MOST_NEG;
        1:       r.value = MOST_POS;
        2:       r.value = ALL_ONES;
        default: r.value = $urandom_range(0, 3);
      endcase
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  function automatic directed_row_t dir_row(req_type_e kind, int unsigned pos,
                                            logic [DATA_W-1:0] val, bit typed,
                                            status_e st, logic [DATA_W-1:0] rd,
                                            int unsigned idx, int unsigned cnt);
    directed_row_t row;
    row.req.req_type    = kind;
    row.req.position    = pos[POS_W-1:0];
    row.req.value       = val;
    row.typed           = typed;
    row.res.status      = st;
    row.res.read_value  = rd;
    row.res.found_index = idx[IDX_OUT_W-1:0];
    row.res.item_count  = cnt[CNT_OUT_W-1:0];
    row.res.is_empty    = (cnt == 0);
    return row;
  endfunction

  // present one request, wait for it to be taken, then log what it should give
  task automatic send_req(req_t r, bit typed, res_t typed_res);
    int unsigned gap;
    res_t        predicted;
    gap = back_to_back ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = list_apply(r);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report_field(string name, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_res = res_o;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, got_res);
        errors++;
      end else begin
        want_res = expected_results.pop_front();
        report_field("status", DATA_W'(want_res.status), DATA_W'(got_res.status));
        report_field("read_value", want_res.read_value, got_res.read_value);
        report_field("found_index", DATA_W'(want_res.found_index),
                     DATA_W'(got_res.found_index));
        report_field("item_count", DATA_W'(want_res.item_count),
                     DATA_W'(got_res.item_count));
        report_field("is_empty", DATA_W'(want_res.is_empty), DATA_W'(got_res.is_empty));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    errors = 0;
    shadow_count = 0;
    back_to_back = 1'b0;
    for (int unsigned i = 0; i < DEPTH; i++) shadow_entries[i] = '0;

    // empty-list corner cases, extremes, then a short walk through every request
    directed_rows[0]  = dir_row(REQ_POP,      0, 0,        1, ST_EMPTY,    0,        0, 0);
    directed_rows[1]  = dir_row(REQ_READ,     0, 0,        1, ST_BADPOS,   0,        0, 0);
    directed_rows[2]  = dir_row(REQ_DELETE, 127, 0,        1, ST_BADPOS,   0,        0, 0);
    directed_rows[3]  = dir_row(REQ_FIND,     0, 0,        1, ST_NOTFOUND, 0,        0, 0);
    directed_rows[4]  = dir_row(REQ_REMOVE,   0, MOST_NEG, 1, ST_NOTFOUND, 0,        0, 0);
    directed_rows[5]  = dir_row(REQ_INSERT,   1, 5,        1, ST_BADPOS,   0,        0, 0);
    directed_rows[6]  = dir_row(REQ_INSERT,   0, MOST_NEG, 1, ST_OK,       0,        0, 1);
    directed_rows[7]  = dir_row(REQ_PUSH,     0, MOST_POS, 1, ST_OK,       0,        0, 2);
    directed_rows[8]  = dir_row(REQ_NONE,   127, ALL_ONES, 1, ST_OK,       0,        0, 2);
    directed_rows[9]  = dir_row(REQ_READ,     0, 0,        1, ST_OK,       MOST_NEG, 0, 2);
    directed_rows[10] = dir_row(REQ_READ,     1, 0,        1, ST_OK,       MOST_POS, 0, 2);
    directed_rows[11] = dir_row(REQ_READ,     2, 0,        1, ST_BADPOS,   0,        0, 2);
    directed_rows[12] = dir_row(REQ_INSERT,   1, ALL_ONES, 1, ST_OK,       0,        0, 3);
    directed_rows[13] = dir_row(REQ_FIND,     0, ALL_ONES, 1, ST_OK,       0,        1, 3);
    directed_rows[14] = dir_row(REQ_PUSH,     0, ALL_ONES, 1, ST_OK,       0,        0, 4);
    directed_rows[15] = dir_row(REQ_REMOVE,   0, ALL_ONES, 1, ST_OK,       0,        0, 3);
    directed_rows[16] = dir_row(REQ_FIND,     0, ALL_ONES, 0, ST_OK,       0,        0, 0);
    directed_rows[17] = dir_row(REQ_DELETE,   0, 0,        1, ST_OK,       0,        0, 2);
    directed_rows[18] = dir_row(REQ_INSERT,   2, 0,        1, ST_OK,       0,        0, 3);
    directed_rows[19] = dir_row(REQ_READ,     2, 0,        0, ST_OK,       0,        0, 0);
    directed_rows[20] = dir_row(REQ_DELETE,   3, 0,        1, ST_BADPOS,   0,        0, 3);
    directed_rows[21] = dir_row(REQ_POP,      0, 0,        1, ST_OK,       0,        0, 2);
    directed_rows[22] = dir_row(REQ_POP,      0, 0,        1, ST_OK,       0,        0, 1);
    directed_rows[23] = dir_row(REQ_POP,      0, 0,        1, ST_OK,       0,        0, 0);
    directed_rows[24] = dir_row(REQ_READ,   127, 0,        1, ST_BADPOS,   0,        0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // random segments: growing traffic, then mixed, then shrinking, then mixed again
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % SEGMENT_LEN == 0) back_to_back = ($urandom_range(0, 3) == 0);
      send_req(random_req(segment_plan[(n / SEGMENT_LEN) % 6]), 1'b0, '0);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
